// ===== src/pae_pkg.sv =====
// Package for the polyphonic envelope block: codes, fixed-point constants,
// per-voice entry, config, control and result structs. No dependencies.
`timescale 1ns / 1ps

package pae_pkg;

  localparam int unsigned COEF_W     = 25;
  localparam int unsigned LVL_W      = 16;
  localparam int unsigned SMP_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 25;

  localparam logic [COEF_W-1:0] ONE_Q24        = 25'd16777216;
  localparam logic [LVL_W-1:0]  FULL_Q15       = 16'd32768;
  localparam logic [LVL_W-1:0]  REL_END_THRESH = 16'd3;
  localparam logic [LVL_W-1:0]  POS_MAX        = 16'd32767;

  localparam logic [COEF_W-1:0] ATTACK_RST  = 25'd2461;
  localparam logic [COEF_W-1:0] DECAY_RST   = 25'd1747627;
  localparam logic [LVL_W-1:0]  SUSTAIN_RST = 16'd24576;
  localparam logic [COEF_W-1:0] RELEASE_RST = 25'd1747627;

  typedef enum logic [1:0] {
    OP_KEY_ON,
    OP_KEY_OFF,
    OP_SAMPLE,
    OP_CONTROL
  } opcode_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ATTACK,
    PH_DECAY,
    PH_SUSTAIN,
    PH_RELEASE,
    PH_DONE
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK,
    REG_DECAY,
    REG_SUSTAIN,
    REG_RELEASE,
    REG_END_FLAG
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_UPD,
    S_MULA,
    S_MULB,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [COEF_W-1:0] attack_coef;
    logic [COEF_W-1:0] decay_coef;
    logic [LVL_W-1:0]  sustain_level;
    logic [COEF_W-1:0] release_coef;
    logic              end_flag_en;
  } cfg_t;

  typedef struct packed {
    logic [LVL_W-1:0]  level;
    logic [LVL_W-1:0]  target;
    logic [COEF_W-1:0] coef;
    phase_e            phase;
    logic [LVL_W-1:0]  velocity;
  } entry_t;

  typedef struct packed {
    logic ld_in;
    logic ld_calc;
    logic ld_upd;
    logic ld_mula;
    logic ld_mulb;
  } ctrl_t;

  typedef struct packed {
    logic [SMP_W-1:0] sample;
    phase_e           phase;
    logic [LVL_W-1:0] level;
    logic             ended;
  } result_t;

endpackage

// ===== src/polyphonic_adsr_envelope.sv =====
// Top level of the polyphonic envelope: sequencer, output register and
// instances of the register file, voice memory and datapath. Depends on pae_pkg.
`timescale 1ns / 1ps

// Each item runs through these steps in order: the voice entry is read from
// the state memory (registered read), the rate times distance product is
// formed, the level is updated and the entry written back, the sample is
// scaled by level and then by velocity, and the result moves into the output
// register. The next item is taken once that result has left the sequencer,
// so the block takes no new item before the last one is in the output
// register. A result waiting in the output register does not stall the next
// item until its own result is ready. Voice state is zero after reset through
// per-entry valid bits, so no clearing pass is needed.
module polyphonic_adsr_envelope #(
  parameter int unsigned NUM_VOICES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pae_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pae_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     opcode_i,
  input  logic [3:0]                     voice_index_i,
  input  logic [15:0]                    velocity_in_i,
  input  logic signed [15:0]             sample_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [15:0]             sample_out_o,
  output logic [2:0]                     phase_o,
  output logic [15:0]                    level_o,
  output logic                           voice_ended_o
);
  import pae_pkg::*;

  localparam int unsigned ADDR_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int unsigned MAX_V  = NUM_VOICES - 1;

  state_e            state_q, state_d;
  ctrl_t             ctrl;
  cfg_t              cfg;
  entry_t            rd_entry, wr_entry;
  result_t           res;
  logic              accept;
  logic              out_load;
  logic [8:0]        vext, vclamp;
  logic [ADDR_W-1:0] addr_in, addr_q;
  logic              out_valid_q, out_valid_d;
  result_t           out_q;

  assign vext    = {5'd0, voice_index_i};
  assign vclamp  = (vext > 9'(MAX_V)) ? 9'(MAX_V) : vext;
  assign addr_in = vclamp[ADDR_W-1:0];

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    ctrl.ld_in   = 1'b0;
    ctrl.ld_calc = 1'b0;
    ctrl.ld_upd  = 1'b0;
    ctrl.ld_mula = 1'b0;
    ctrl.ld_mulb = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl.ld_in = 1'b1;
          state_d    = S_CALC;
        end
      end
      S_CALC: begin
        ctrl.ld_calc = 1'b1;
        state_d      = S_UPD;
      end
      S_UPD: begin
        ctrl.ld_upd = 1'b1;
        state_d     = S_MULA;
      end
      S_MULA: begin
        ctrl.ld_mula = 1'b1;
        state_d      = S_MULB;
      end
      S_MULB: begin
        ctrl.ld_mulb = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= addr_in;
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  pae_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pae_voice_mem #(
    .NUM_VOICES (NUM_VOICES),
    .ADDR_W     (ADDR_W)
  ) u_voice_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (addr_in),
    .rd_data_o (rd_entry),
    .wr_en_i   (ctrl.ld_upd),
    .wr_addr_i (addr_q),
    .wr_data_i (wr_entry)
  );

  pae_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .ctrl_i     (ctrl),
    .opcode_i   (opcode_i),
    .sample_i   (sample_in_i),
    .velocity_i (velocity_in_i),
    .rd_entry_i (rd_entry),
    .wr_entry_o (wr_entry),
    .result_o   (res)
  );

  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = out_q.sample;
  assign phase_o       = out_q.phase;
  assign level_o       = out_q.level;
  assign voice_ended_o = out_q.ended;

  // a pending result is only replaced in the cycle it transfers
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_valid_q) |-> out_ready_i)
    else $error("output register overwritten before transfer");

  // an accepted item always reaches write-back, via calc
  a_accept_to_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 (state_q == S_UPD))
    else $error("sequencer skipped the entry update");

endmodule

// ===== src/pae_cfg_regs.sv =====
// Global envelope registers with range clamping on write.
// Depends on pae_pkg.
`timescale 1ns / 1ps

module pae_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pae_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pae_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output pae_pkg::cfg_t                  cfg_o
);
  import pae_pkg::*;

  cfg_t                cfg_q, cfg_d;
  logic [COEF_W-1:0]   coef_clamped;
  logic [LVL_W-1:0]    sus_clamped;

  assign coef_clamped = (cfg_wdata_i > ONE_Q24) ? ONE_Q24 : cfg_wdata_i;
  assign sus_clamped  = (cfg_wdata_i[LVL_W-1:0] > FULL_Q15) ? FULL_Q15
                                                             : cfg_wdata_i[LVL_W-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ATTACK:   cfg_d.attack_coef   = coef_clamped;
        REG_DECAY:    cfg_d.decay_coef    = coef_clamped;
        REG_SUSTAIN:  cfg_d.sustain_level = sus_clamped;
        REG_RELEASE:  cfg_d.release_coef  = coef_clamped;
        REG_END_FLAG: cfg_d.end_flag_en   = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_coef   <= ATTACK_RST;
      cfg_q.decay_coef    <= DECAY_RST;
      cfg_q.sustain_level <= SUSTAIN_RST;
      cfg_q.release_coef  <= RELEASE_RST;
      cfg_q.end_flag_en   <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/pae_voice_mem.sv =====
// Per-voice state memory, one write and one registered read port.
// Entries read as zero (idle voice) until first written. Depends on pae_pkg.
`timescale 1ns / 1ps

module pae_voice_mem #(
  parameter int unsigned NUM_VOICES = 16,
  parameter int unsigned ADDR_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output pae_pkg::entry_t   rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  pae_pkg::entry_t   wr_data_i
);
  import pae_pkg::*;

  entry_t                mem [NUM_VOICES];
  logic [NUM_VOICES-1:0] vld_q;
  entry_t                rd_data_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

  // the sequencer never reads an entry in the cycle it is written back
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en_i && wr_en_i && (rd_addr_i == wr_addr_i)))
    else $error("read and write of the same voice entry in one cycle");

endmodule

// ===== src/pae_datapath.sv =====
// Envelope step and sample scaling datapath: coefficient multiply, level
// update, two chained scaling multiplies, rounding and saturation.
// Depends on pae_pkg.
`timescale 1ns / 1ps

module pae_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pae_pkg::cfg_t             cfg_i,
  input  pae_pkg::ctrl_t            ctrl_i,
  input  logic [1:0]                opcode_i,
  input  logic [pae_pkg::SMP_W-1:0] sample_i,
  input  logic [pae_pkg::LVL_W-1:0] velocity_i,
  input  pae_pkg::entry_t           rd_entry_i,
  output pae_pkg::entry_t           wr_entry_o,
  output pae_pkg::result_t          result_o
);
  import pae_pkg::*;

  localparam int unsigned P1_W = COEF_W + LVL_W;
  localparam int unsigned PA_W = SMP_W + LVL_W;
  localparam int unsigned PB_W = PA_W + LVL_W;

  opcode_e           op_q;
  logic [SMP_W-1:0]  smp_q;
  logic [LVL_W-1:0]  vel_q;
  entry_t            ent_q;
  logic [LVL_W-1:0]  dist_q;
  logic              up_q;
  logic [P1_W-1:0]   p1_q;
  entry_t            nxt_d, nxt_q;
  logic              ended_d, ended_q;
  logic [PA_W-1:0]   pa_q;
  logic [PB_W-1:0]   pb_q;

  logic [LVL_W-1:0]  rd_dist;
  logic              rd_up;
  logic [P1_W:0]     p1_rnd;
  logic [P1_W-24:0]  step;
  logic [LVL_W-1:0]  lvl_stepped;
  logic              neg;
  logic [SMP_W-1:0]  mag;
  logic [PB_W:0]     pb_rnd;
  logic [PB_W-30:0]  r;
  logic [SMP_W-1:0]  sat;

  // distance to target of the entry just read
  assign rd_up   = rd_entry_i.target >= rd_entry_i.level;
  assign rd_dist = rd_up ? (rd_entry_i.target - rd_entry_i.level)
                         : (rd_entry_i.level - rd_entry_i.target);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_in) begin
      op_q  <= opcode_e'(opcode_i);
      smp_q <= sample_i;
      vel_q <= (velocity_i > FULL_Q15) ? FULL_Q15 : velocity_i;
    end
    if (ctrl_i.ld_calc) begin
      ent_q  <= rd_entry_i;
      dist_q <= rd_dist;
      up_q   <= rd_up;
      p1_q   <= rd_entry_i.coef * rd_dist;
    end
    if (ctrl_i.ld_upd) begin
      nxt_q   <= nxt_d;
      ended_q <= ended_d;
    end
    if (ctrl_i.ld_mula) begin
      pa_q <= mag * nxt_q.level;
    end
    if (ctrl_i.ld_mulb) begin
      pb_q <= pa_q * nxt_q.velocity;
    end
  end

  // one-pole step, at least one lsb when moving, never past the target
  always_comb begin
    p1_rnd = {1'b0, p1_q} + (P1_W+1)'(1 << 23);
    step   = p1_rnd[P1_W:24];
    if ((ent_q.coef != '0) && (dist_q != '0) && (step == '0)) begin
      step = (P1_W-23)'(1);
    end
    if (step > (P1_W-23)'(dist_q)) begin
      step = (P1_W-23)'(dist_q);
    end
    lvl_stepped = up_q ? (ent_q.level + step[LVL_W-1:0])
                       : (ent_q.level - step[LVL_W-1:0]);
  end

  always_comb begin
    nxt_d   = ent_q;
    ended_d = 1'b0;
    case (op_q)
      OP_KEY_ON: begin
        nxt_d.level    = '0;
        nxt_d.target   = FULL_Q15;
        nxt_d.phase    = PH_ATTACK;
        nxt_d.coef     = cfg_i.attack_coef;
        nxt_d.velocity = vel_q;
      end
      OP_KEY_OFF: begin
        nxt_d.target = '0;
        nxt_d.phase  = PH_RELEASE;
        nxt_d.coef   = cfg_i.release_coef;
      end
      OP_SAMPLE: begin
        nxt_d.level = lvl_stepped;
      end
      OP_CONTROL: begin
        case (ent_q.phase)
          PH_ATTACK: begin
            if (ent_q.level >= ent_q.target) begin
              nxt_d.coef   = cfg_i.decay_coef;
              nxt_d.target = cfg_i.sustain_level;
              nxt_d.phase  = PH_DECAY;
            end
          end
          PH_DECAY: begin
            if (ent_q.level <= cfg_i.sustain_level) begin
              nxt_d.coef  = '0;
              nxt_d.phase = PH_SUSTAIN;
            end
          end
          PH_RELEASE: begin
            if (ent_q.level <= REL_END_THRESH) begin
              nxt_d.phase = PH_DONE;
              ended_d     = cfg_i.end_flag_en;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign neg = smp_q[SMP_W-1];
  assign mag = neg ? (~smp_q + SMP_W'(1)) : smp_q;

  // round half away from zero on the magnitude, then saturate per sign
  always_comb begin
    pb_rnd = {1'b0, pb_q} + (PB_W+1)'(1 << 29);
    r      = pb_rnd[PB_W:30];
    if (neg) begin
      sat = (r > (PB_W-29)'(FULL_Q15)) ? FULL_Q15 : r[SMP_W-1:0];
      sat = ~sat + SMP_W'(1);
    end else begin
      sat = (r > (PB_W-29)'(POS_MAX)) ? POS_MAX : r[SMP_W-1:0];
    end
  end

  assign wr_entry_o      = nxt_d;
  assign result_o.sample = (op_q == OP_SAMPLE) ? sat : '0;
  assign result_o.phase  = nxt_q.phase;
  assign result_o.level  = nxt_q.level;
  assign result_o.ended  = ended_q;

  a_level_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.ld_upd |=> (nxt_q.level <= FULL_Q15))
    else $error("envelope level above full scale");

  a_ended_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.ld_upd |=> (!ended_q || (nxt_q.phase == PH_DONE)))
    else $error("voice ended flag without done phase");

endmodule

// ===== tb/tb_polyphonic_adsr_envelope.sv =====
// Self-checking testbench for polyphonic_adsr_envelope: a queue-fed driver, a monitor
// with a per-voice envelope predictor, and a randomly stalling result sink.
// Depends on pae_pkg and the polyphonic_adsr_envelope RTL.
`timescale 1ns / 1ps

module tb_polyphonic_adsr_envelope;
  import pae_pkg::*;

  localparam int unsigned NUM_VOICES  = 16;
  localparam int unsigned HOLD_CYCLES = 250;
  localparam int unsigned PHASE_ITEMS = 100;

  typedef enum {
    MODE_NONE,
    MODE_SEND,
    MODE_RECV,
    MODE_BOTH,
    MODE_PRESSURE
  } traffic_e;

  typedef struct {
    opcode_e     op;
    logic [3:0]  voice;
    logic [15:0] velocity;
    logic [15:0] sample;
  } env_item_t;

  logic                    clk_i;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i   = '0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              opcode_i      = '0;
  logic [3:0]              voice_index_i = '0;
  logic [15:0]             velocity_in_i = '0;
  logic signed [15:0]      sample_in_i   = '0;
  logic                    out_valid_o;
  logic                    out_ready_i   = 1'b0;
  logic signed [15:0]      sample_out_o;
  logic [2:0]              phase_o;
  logic [15:0]             level_o;
  logic                    voice_ended_o;

  // predictor copy of the register file and the voice memory
  logic [COEF_W-1:0] atk_rate   = ATTACK_RST;
  logic [COEF_W-1:0] dec_rate   = DECAY_RST;
  logic [LVL_W-1:0]  sus_level  = SUSTAIN_RST;
  logic [COEF_W-1:0] rel_rate   = RELEASE_RST;
  logic              end_flag   = 1'b1;
  logic [LVL_W-1:0]  voice_lvl  [NUM_VOICES];
  logic [LVL_W-1:0]  voice_tgt  [NUM_VOICES];
  logic [COEF_W-1:0] voice_rate [NUM_VOICES];
  phase_e            voice_ph   [NUM_VOICES];
  logic [LVL_W-1:0]  voice_vel  [NUM_VOICES];

  env_item_t pending_q[$];
  result_t   envelope_q[$];
  env_item_t next_item;
  traffic_e  run_mode     = MODE_NONE;
  int        issued_cnt   = 0;
  int        accepted_cnt = 0;
  int        mismatches   = 0;
  int        hold_cnt     = 0;
  logic      in_taken     = 1'b0;

  polyphonic_adsr_envelope #(
    .NUM_VOICES(NUM_VOICES)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .voice_index_i(voice_index_i),
    .velocity_in_i(velocity_in_i),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .phase_o      (phase_o),
    .level_o      (level_o),
    .voice_ended_o(voice_ended_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic result_t predict_envelope(opcode_e op, logic [3:0] vin,
                                               logic [15:0] vel, logic [15:0] smp);
    result_t     res;
    int unsigned v;
    logic [15:0] lvl;
    logic [15:0] tgt;
    logic [15:0] gap;
    logic [16:0] mag;
    logic [63:0] step;
    logic [63:0] prod;
    logic [63:0] rnd;
    v = vin;
    if (v > NUM_VOICES - 1) v = NUM_VOICES - 1;
    res = '0;
    case (op)
      OP_KEY_ON: begin
        voice_lvl[v]  = '0;
        voice_tgt[v]  = FULL_Q15;
        voice_ph[v]   = PH_ATTACK;
        voice_rate[v] = atk_rate;
        voice_vel[v]  = (vel > FULL_Q15) ? FULL_Q15 : vel;
      end
      OP_KEY_OFF: begin
        voice_tgt[v]  = '0;
        voice_ph[v]   = PH_RELEASE;
        voice_rate[v] = rel_rate;
      end
      OP_SAMPLE: begin
        lvl  = voice_lvl[v];
        tgt  = voice_tgt[v];
        gap  = (tgt >= lvl) ? tgt - lvl : lvl - tgt;
        step = (64'(voice_rate[v]) * gap + (64'd1 << 23)) >> 24;
        // any nonzero rate moves at least one lsb
        if (voice_rate[v] != 0 && gap != 0 && step == 0) step = 1;
        if (step > gap) step = gap;
        voice_lvl[v] = (tgt >= lvl) ? lvl + step[15:0] : lvl - step[15:0];
        mag  = smp[15] ? 17'h10000 - smp : {1'b0, smp};
        prod = 64'(mag) * voice_lvl[v] * voice_vel[v];
        rnd  = (prod + (64'd1 << 29)) >> 30;
        if (smp[15]) begin
          if (rnd > 32768) rnd = 32768;
          res.sample = 16'd0 - rnd[15:0];
        end else begin
          if (rnd > 32767) rnd = 32767;
          res.sample = rnd[15:0];
        end
      end
      default: begin
        case (voice_ph[v])
          PH_ATTACK: begin
            if (voice_lvl[v] >= voice_tgt[v]) begin
              voice_rate[v] = dec_rate;
              voice_tgt[v]  = sus_level;
              voice_ph[v]   = PH_DECAY;
            end
          end
          PH_DECAY: begin
            if (voice_lvl[v] <= sus_level) begin
              voice_rate[v] = '0;
              voice_ph[v]   = PH_SUSTAIN;
            end
          end
          PH_RELEASE: begin
            if (voice_lvl[v] <= REL_END_THRESH) begin
              voice_ph[v] = PH_DONE;
              res.ended   = end_flag;
            end
          end
          default: ;
        endcase
      end
    endcase
    res.phase = voice_ph[v];
    res.level = voice_lvl[v];
    return res;
  endfunction

  function automatic bit roll(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  // sender: a new item only once the current one has been transferred
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_q.size() != 0 &&
          !((run_mode == MODE_SEND && roll(58)) || (run_mode == MODE_BOTH && roll(28)))) begin
        next_item     = pending_q.pop_front();
        in_valid_i    <= 1'b1;
        opcode_i      <= next_item.op;
        voice_index_i <= next_item.voice;
        velocity_in_i <= next_item.velocity;
        sample_in_i   <= next_item.sample;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result sink, with one long hold-off at the start of the pressure phase
  always @(negedge clk_i) begin
    if (run_mode == MODE_PRESSURE && hold_cnt < HOLD_CYCLES) begin
      hold_cnt    <= hold_cnt + 1;
      out_ready_i <= 1'b0;
    end else begin
      if (run_mode != MODE_PRESSURE) hold_cnt <= 0;
      out_ready_i <= !((run_mode == MODE_RECV && roll(58)) ||
                       (run_mode == MODE_BOTH && roll(28)));
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (envelope_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing pending: sample %0d phase %0d level %0d ended %0b",
                     $time, sample_out_o, phase_o, level_o, voice_ended_o);
        end else begin
          want = envelope_q.pop_front();
          if (sample_out_o !== want.sample || phase_o !== want.phase ||
              level_o !== want.level || voice_ended_o !== want.ended) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected sample %0d phase %0d level %0d ended %0b, got %0d %0d %0d %0b",
                       $time, $signed(want.sample), want.phase, want.level, want.ended,
                       sample_out_o, phase_o, level_o, voice_ended_o);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        in_taken = 1'b1;
        accepted_cnt++;
        envelope_q.push_back(predict_envelope(opcode_e'(opcode_i), voice_index_i,
                                              velocity_in_i, sample_in_i));
      end
    end
  end

  task automatic push_item(opcode_e op, logic [3:0] voice, logic [15:0] vel,
                           logic [15:0] smp);
    env_item_t it;
    it.op       = op;
    it.voice    = voice;
    it.velocity = vel;
    it.sample   = smp;
    pending_q.push_back(it);
    issued_cnt++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ATTACK:   atk_rate  = (val > ONE_Q24) ? ONE_Q24 : val;
      REG_DECAY:    dec_rate  = (val > ONE_Q24) ? ONE_Q24 : val;
      REG_SUSTAIN:  sus_level = (val[15:0] > FULL_Q15) ? FULL_Q15 : val[15:0];
      REG_RELEASE:  rel_rate  = (val > ONE_Q24) ? ONE_Q24 : val;
      REG_END_FLAG: end_flag  = val[0];
      default: ;
    endcase
  endtask

  // idle means every item transferred and every result checked
  task automatic wait_drained();
    while (accepted_cnt != issued_cnt || envelope_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] fast_rate();
    return CFG_DATA_W'($urandom_range(ONE_Q24 / 4, ONE_Q24));
  endfunction

  task automatic apply_settings(int k);
    case (k)
      0: begin
        write_reg(REG_ATTACK, ONE_Q24);
        write_reg(REG_DECAY, ONE_Q24);
        write_reg(REG_SUSTAIN, '0);
        write_reg(REG_RELEASE, ONE_Q24);
        write_reg(REG_END_FLAG, CFG_DATA_W'(1));
        run_mode = MODE_NONE;
      end
      1: begin
        write_reg(REG_ATTACK, fast_rate());
        write_reg(REG_DECAY, fast_rate());
        write_reg(REG_SUSTAIN, CFG_DATA_W'($urandom_range(FULL_Q15)));
        write_reg(REG_RELEASE, fast_rate());
        write_reg(REG_END_FLAG, '0);
        run_mode = MODE_SEND;
      end
      2: begin
        write_reg(REG_ATTACK, fast_rate());
        write_reg(REG_DECAY, '0);
        write_reg(REG_SUSTAIN, CFG_DATA_W'(16'hFFFF));
        write_reg(REG_RELEASE, fast_rate());
        write_reg(REG_END_FLAG, CFG_DATA_W'($urandom) | CFG_DATA_W'(1));
        run_mode = MODE_RECV;
      end
      3: begin
        write_reg(REG_ATTACK, '0);
        write_reg(REG_DECAY, fast_rate());
        write_reg(REG_SUSTAIN, CFG_DATA_W'($urandom_range(FULL_Q15)));
        write_reg(REG_RELEASE, '1);
        run_mode = MODE_BOTH;
      end
      4: begin
        // writes to unused indexes must leave every register alone
        for (int i = int'(REG_END_FLAG) + 1; i < 2 ** CFG_IDX_W; i++)
          write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
        write_reg(REG_ATTACK, fast_rate());
        write_reg(REG_DECAY, fast_rate());
        write_reg(REG_RELEASE, fast_rate());
        write_reg(REG_END_FLAG, CFG_DATA_W'($urandom) & ~CFG_DATA_W'(1));
        run_mode = MODE_PRESSURE;
      end
      default: begin
        write_reg(REG_ATTACK, CFG_DATA_W'($urandom_range(1 << 16)));
        write_reg(REG_DECAY, fast_rate());
        write_reg(REG_SUSTAIN, CFG_DATA_W'($urandom_range(FULL_Q15)));
        write_reg(REG_RELEASE, fast_rate());
        write_reg(REG_END_FLAG, CFG_DATA_W'(1));
        run_mode = MODE_NONE;
      end
    endcase
  endtask

  // most traffic goes to a few voices so that their envelopes run through all phases
  task automatic queue_random_items(int n);
    logic [3:0]  hot [3];
    logic [3:0]  voice;
    logic [15:0] vel;
    int unsigned r;
    opcode_e     op;
    foreach (hot[i]) hot[i] = 4'($urandom_range(15));
    for (int i = 0; i < n; i++) begin
      r     = $urandom_range(99);
      voice = ($urandom_range(3) != 0) ? hot[$urandom_range(2)] : 4'($urandom_range(15));
      op    = (r < 5) ? OP_KEY_ON : (r < 10) ? OP_KEY_OFF : (r < 65) ? OP_SAMPLE : OP_CONTROL;
      vel   = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(FULL_Q15));
      push_item(op, voice, vel, 16'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_VOICES; i++) begin
      voice_lvl[i]  = '0;
      voice_tgt[i]  = '0;
      voice_rate[i] = '0;
      voice_ph[i]   = PH_IDLE;
      voice_vel[i]  = '0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: idle voices, slow attack, key off from idle and from done
    push_item(OP_CONTROL, 4'd0, 16'd0, 16'h0000);
    push_item(OP_SAMPLE, 4'd0, 16'd0, 16'h8000);
    push_item(OP_KEY_ON, 4'd1, 16'hFFFF, 16'h0000);
    push_item(OP_SAMPLE, 4'd1, 16'd0, 16'h7FFF);
    push_item(OP_CONTROL, 4'd1, 16'd0, 16'h0000);
    push_item(OP_KEY_OFF, 4'd2, 16'd0, 16'h0000);
    push_item(OP_CONTROL, 4'd2, 16'd0, 16'h0000);
    push_item(OP_CONTROL, 4'd2, 16'd0, 16'h0000);
    push_item(OP_KEY_OFF, 4'd2, 16'd0, 16'h0000);
    push_item(OP_SAMPLE, 4'd2, 16'd0, 16'h7FFF);
    wait_drained();

    // instant attack and decay, over-range attack write, one-lsb release
    write_reg(REG_ATTACK, '1);
    write_reg(REG_DECAY, ONE_Q24);
    write_reg(REG_SUSTAIN, CFG_DATA_W'(16384));
    write_reg(REG_RELEASE, CFG_DATA_W'(1));
    write_reg(REG_END_FLAG, CFG_DATA_W'(1));
    push_item(OP_KEY_ON, 4'd15, FULL_Q15, 16'h0000);
    push_item(OP_SAMPLE, 4'd15, 16'd0, 16'h8000);
    push_item(OP_SAMPLE, 4'd15, 16'd0, 16'h7FFF);
    push_item(OP_CONTROL, 4'd15, 16'd0, 16'h0000);
    push_item(OP_SAMPLE, 4'd15, 16'd0, 16'h0001);
    push_item(OP_SAMPLE, 4'd15, 16'd0, 16'hFFFF);
    push_item(OP_CONTROL, 4'd15, 16'd0, 16'h0000);
    push_item(OP_KEY_OFF, 4'd15, 16'd0, 16'h0000);
    push_item(OP_SAMPLE, 4'd15, 16'd0, 16'd100);
    push_item(OP_CONTROL, 4'd15, 16'd0, 16'h0000);
    push_item(OP_KEY_ON, 4'd1, 16'd0, 16'h0000);
    push_item(OP_SAMPLE, 4'd1, 16'd0, 16'h8000);
    push_item(OP_KEY_OFF, 4'd1, 16'd0, 16'h0000);
    push_item(OP_SAMPLE, 4'd1, 16'd0, 16'h1234);
    wait_drained();

    for (int k = 0; k < 6; k++) begin
      apply_settings(k);
      queue_random_items(PHASE_ITEMS);
      wait_drained();
    end
    run_mode = MODE_NONE;
    repeat (20) @(negedge clk_i);
    mismatches += envelope_q.size();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== polyphonic_adsr_envelope.f =====
src/pae_pkg.sv
src/pae_cfg_regs.sv
src/pae_voice_mem.sv
src/pae_datapath.sv
src/polyphonic_adsr_envelope.sv
tb/tb_polyphonic_adsr_envelope.sv
